@@ rtl/i2cm_pkg.sv @@
package i2cm_pkg;

    localparam int unsigned BITS_PER_BYTE = 8;
    localparam int unsigned BIT_CNT_W = $clog2(BITS_PER_BYTE + 1);
    localparam int unsigned TICK_W = 16;
    localparam logic [TICK_W-1:0] PHASE_TICKS_RST = 16'd200;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_STOP  = 2'd1,
        MODE_WRITE = 2'd2,
        MODE_READ  = 2'd3
    } i2cm_mode_t;

    typedef struct packed {
        logic       cmd_valid;
        i2cm_mode_t mode;
        logic [7:0] tx_data;
        logic       send_ack;
        logic       scl_in;
        logic       sda_in;
    } i2cm_in_t;

    typedef struct packed {
        logic       scl_pull_low;
        logic       sda_pull_low;
        logic       busy_res;
        logic       cmd_done;
        logic [7:0] rx_data;
        logic       slave_acked;
    } i2cm_out_t;

endpackage

@@ rtl/i2cm_engine.sv @@
// Bus phase sequencer: one tick per enabled cycle.
module i2cm_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  i2cm_pkg::i2cm_in_t            tick,
    input  logic                          cfg_we,
    input  logic [i2cm_pkg::TICK_W-1:0]   cfg_wdata,
    output i2cm_pkg::i2cm_out_t           res
);
    import i2cm_pkg::*;

    typedef enum logic [3:0] {
        PH_FREE     = 4'd0,
        PH_HELD     = 4'd1,
        PH_ST_PREP  = 4'd2,
        PH_ST_REL   = 4'd3,
        PH_ST_SDA   = 4'd4,
        PH_ST_LOW   = 4'd5,
        PH_SP_LOW   = 4'd6,
        PH_SP_SCL   = 4'd7,
        PH_SP_REL   = 4'd8,
        PH_BIT_LOW  = 4'd9,
        PH_BIT_HIGH = 4'd10,
        PH_TAIL     = 4'd11
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [BIT_CNT_W-1:0]   bit_count_reg, bit_count_next;
    logic [7:0]             shift_byte_reg, shift_byte_next;
    logic [TICK_W-1:0]      tick_count_reg, tick_count_next;
    i2cm_mode_t             active_mode_reg, active_mode_next;
    logic                   ack_to_send_reg, ack_to_send_next;
    logic                   ack_seen_reg, ack_seen_next;
    logic [7:0]             rx_hold_reg, rx_hold_next;
    logic [TICK_W-1:0]      phase_ticks_reg;

    logic                   idle;
    logic                   idle_next;
    logic                   scl_drv_cur;
    logic                   scl_drv_next;
    logic                   sda_drv_next;
    logic                   done;
    logic [TICK_W-1:0]      limit;
    logic [TICK_W-1:0]      tick_inc;
    logic                   byte_left;

    assign idle      = (phase_reg == PH_FREE) || (phase_reg == PH_HELD);
    assign idle_next = (phase_next == PH_FREE) || (phase_next == PH_HELD);
    assign limit     = (phase_ticks_reg == '0) ? TICK_W'(1) : phase_ticks_reg;
    assign tick_inc  = tick_count_reg + TICK_W'(1);
    assign byte_left = bit_count_reg < BIT_CNT_W'(BITS_PER_BYTE);

    // SCL is pulled low in these phases; all others release it
    function automatic logic scl_low(phase_t ph);
        logic r;
        unique case (ph)
            PH_HELD, PH_ST_PREP, PH_ST_LOW, PH_SP_LOW, PH_BIT_LOW, PH_TAIL: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    assign scl_drv_cur  = scl_low(phase_reg);
    assign scl_drv_next = scl_low(phase_next);

    always_comb begin
        phase_next       = phase_reg;
        bit_count_next   = bit_count_reg;
        shift_byte_next  = shift_byte_reg;
        tick_count_next  = tick_count_reg;
        active_mode_next = active_mode_reg;
        ack_to_send_next = ack_to_send_reg;
        ack_seen_next    = ack_seen_reg;
        rx_hold_next     = rx_hold_reg;
        done             = 1'b0;

        if (idle) begin
            if (tick.cmd_valid) begin
                active_mode_next = tick.mode;
                ack_to_send_next = tick.send_ack;
                bit_count_next   = '0;
                tick_count_next  = '0;
                unique case (tick.mode)
                    MODE_START: begin
                        phase_next = (phase_reg == PH_HELD) ? PH_ST_PREP : PH_ST_REL;
                    end
                    MODE_STOP: begin
                        // stop on a free bus finishes at once
                        if (phase_reg == PH_HELD) begin
                            phase_next = PH_SP_LOW;
                        end else begin
                            done = 1'b1;
                        end
                    end
                    MODE_WRITE: begin
                        shift_byte_next = tick.tx_data;
                        phase_next      = PH_BIT_LOW;
                    end
                    MODE_READ: begin
                        shift_byte_next = '0;
                        phase_next      = PH_BIT_LOW;
                    end
                    default: ;
                endcase
            end
        end else if (scl_drv_cur || tick.scl_in) begin
            // released-SCL phases stall here while a slave stretches the clock
            tick_count_next = tick_inc;
            if (tick_inc >= limit) begin
                tick_count_next = '0;
                unique case (phase_reg)
                    PH_ST_PREP: phase_next = PH_ST_REL;
                    PH_ST_REL:  phase_next = PH_ST_SDA;
                    PH_ST_SDA:  phase_next = PH_ST_LOW;
                    PH_ST_LOW: begin
                        phase_next = PH_HELD;
                        done       = 1'b1;
                    end
                    PH_SP_LOW:  phase_next = PH_SP_SCL;
                    PH_SP_SCL:  phase_next = PH_SP_REL;
                    PH_SP_REL: begin
                        phase_next = PH_FREE;
                        done       = 1'b1;
                    end
                    PH_BIT_LOW: phase_next = PH_BIT_HIGH;
                    PH_BIT_HIGH: begin
                        if (byte_left) begin
                            shift_byte_next = {shift_byte_reg[6:0],
                                               (active_mode_reg == MODE_READ) & tick.sda_in};
                            bit_count_next  = bit_count_reg + BIT_CNT_W'(1);
                            phase_next      = PH_BIT_LOW;
                        end else begin
                            if (active_mode_reg == MODE_WRITE) begin
                                ack_seen_next = ~tick.sda_in;
                            end else begin
                                rx_hold_next = shift_byte_reg;
                            end
                            phase_next = PH_TAIL;
                        end
                    end
                    PH_TAIL: begin
                        phase_next = PH_HELD;
                        done       = 1'b1;
                    end
                    default: phase_next = PH_FREE;
                endcase
            end
        end
    end

    // SDA drive from the state after this tick
    always_comb begin
        unique case (phase_next)
            PH_HELD, PH_ST_SDA, PH_ST_LOW, PH_SP_LOW, PH_SP_SCL: sda_drv_next = 1'b1;
            PH_BIT_LOW, PH_BIT_HIGH: begin
                if (bit_count_next < BIT_CNT_W'(BITS_PER_BYTE)) begin
                    sda_drv_next = (active_mode_next == MODE_WRITE) & ~shift_byte_next[7];
                end else begin
                    sda_drv_next = (active_mode_next == MODE_READ) & ack_to_send_next;
                end
            end
            PH_TAIL: sda_drv_next = (active_mode_next == MODE_READ) & ack_to_send_next;
            default: sda_drv_next = 1'b0;
        endcase
    end

    always_comb begin
        res.scl_pull_low = scl_drv_next;
        res.sda_pull_low = sda_drv_next;
        res.busy_res     = ~idle_next;
        res.cmd_done     = done;
        res.rx_data      = rx_hold_next;
        res.slave_acked  = ack_seen_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_FREE;
            bit_count_reg   <= '0;
            shift_byte_reg  <= '0;
            tick_count_reg  <= '0;
            active_mode_reg <= MODE_START;
            ack_to_send_reg <= 1'b0;
            ack_seen_reg    <= 1'b0;
            rx_hold_reg     <= '0;
            phase_ticks_reg <= PHASE_TICKS_RST;
        end else begin
            if (en) begin
                phase_reg       <= phase_next;
                bit_count_reg   <= bit_count_next;
                shift_byte_reg  <= shift_byte_next;
                tick_count_reg  <= tick_count_next;
                active_mode_reg <= active_mode_next;
                ack_to_send_reg <= ack_to_send_next;
                ack_seen_reg    <= ack_seen_next;
                rx_hold_reg     <= rx_hold_next;
            end
            if (cfg_we) begin
                phase_ticks_reg <= cfg_wdata;
            end
        end
    end

    a_tick_only_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_count_reg != '0 |-> !idle)
        else $error("phase counter running while idle");

    a_bit_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_count_reg <= BIT_CNT_W'(BITS_PER_BYTE))
        else $error("bit counter past ACK slot");

    a_done_ends_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        en && done |-> idle_next)
        else $error("done flagged with command still running");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(phase_reg) && $stable(tick_count_reg) && $stable(shift_byte_reg))
        else $error("engine state moved without a tick");

endmodule

@@ rtl/i2c_master_byte_engine.sv @@
// Channel  | Ports                          | Word
// ---------+--------------------------------+-------------------------------------
// input    | s_valid s_ready s_data         | one bus tick: command + sampled lines
// result   | m_valid m_ready m_data         | drives, busy, done, rx byte, ack
// config   | cfg_valid cfg_ready cfg_data   | phase_ticks (ticks per bus phase)
//
// One word in, one word out, one word per cycle sustained while m_ready is high; each word
// passes the input register, then the phase sequencer into the result register.
// aresetn is synchronous, active low; phase_ticks resets to 200.
// A stall on m_ready freezes the sequencer; the input register still takes one
// word, then s_ready drops until the result register drains.
// cfg_ready is always high; write phase_ticks only while the engine is idle.
module i2c_master_byte_engine (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  i2cm_pkg::i2cm_in_t            s_data,

    output logic                          m_valid,
    input  logic                          m_ready,
    output i2cm_pkg::i2cm_out_t           m_data,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [i2cm_pkg::TICK_W-1:0]   cfg_data
);
    import i2cm_pkg::*;

    // input stage
    i2cm_in_t   in_reg;
    logic       in_vld_reg;

    // result stage
    i2cm_out_t  out_reg;
    logic       out_vld_reg;

    i2cm_out_t  res;
    logic       adv;    // sequencer consumes the held tick this cycle

    assign adv       = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || adv;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_vld_reg;
    assign m_data    = out_reg;

    i2cm_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .tick      (in_reg),
        .cfg_we    (cfg_valid),
        .cfg_wdata (cfg_data),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
            end else if (adv) begin
                in_vld_reg <= 1'b0;
            end

            if (adv) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (adv) begin
            out_reg <= res;
        end
    end

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && !m_ready |=> out_vld_reg && $stable(out_reg))
        else $error("result word dropped under stall");

    a_in_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !adv |=> in_vld_reg && $stable(in_reg))
        else $error("held tick lost before the sequencer took it");

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && out_reg.cmd_done |-> !out_reg.busy_res)
        else $error("done reported while busy");

endmodule
